[rtl/thermal_derating_limiter_core_macros.svh]
// Assertion macros for the thermal derating limiter checker.
// Needs clk and arst_n in the scope of each use.
`ifndef THERMAL_DERATING_LIMITER_CORE_MACROS_SVH
`define THERMAL_DERATING_LIMITER_CORE_MACROS_SVH

// same-cycle implication
`define TDL_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication
`define TDL_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) else $error(msg);

`endif

[rtl/tdl_pkg.sv]
// Shared types and constants of the thermal derating limiter.
// No dependencies; used by every other file of the block but the assertion macros header.
package tdl_pkg;

	localparam int ACC_WIDTH_DEF = 24;

	localparam int SAMPLE_W   = 8;
	localparam int PWM_W      = 14;
	localparam int STATUS_W   = 2;
	localparam int DEG_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int SHIFT_W    = 4;
	localparam int MUL_A_W    = PWM_W;
	localparam int MUL_B_W    = 8;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_AVG_SHIFT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LEVEL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DERATING_SLOPE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_SCALE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_OFFSET  = 3'd5;

	// limit status codes
	localparam logic [STATUS_W-1:0] STAT_NORMAL  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_DERATED = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_CUT     = 2'd2;

	// shared unit operations
	localparam logic ALU_OP_ACC = 1'b0;
	localparam logic ALU_OP_MUL = 1'b1;

	typedef struct packed {
		logic [SHIFT_W-1:0] avg_shift;
		logic [7:0]         limit_level;
		logic [7:0]         max_level;
		logic [7:0]         derating_slope;
		logic [7:0]         degree_scale;
		logic [7:0]         degree_offset;
	} cfg_t;

	typedef struct packed {
		logic               op;
		logic [SAMPLE_W-1:0] sub_b;
		logic [SAMPLE_W-1:0] add_c;
		logic [MUL_A_W-1:0] mul_a;
		logic [MUL_B_W-1:0] mul_b;
	} alu_req_t;

endpackage

[rtl/tdl_if.sv]
// Valid/ready channel interfaces for sample items and result items.
// Depends on tdl_pkg for field widths.
interface tdl_in_if import tdl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] adc_sample;
	logic [PWM_W-1:0]    pwm_request;

	modport source (output valid, adc_sample, pwm_request, input ready);
	modport sink (input valid, adc_sample, pwm_request, output ready);
endinterface

interface tdl_out_if import tdl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [PWM_W-1:0]    pwm_limited;
	logic [STATUS_W-1:0] limit_status;
	logic [DEG_W-1:0]    degrees;

	modport source (output valid, pwm_limited, limit_status, degrees, input ready);
	modport sink (input valid, pwm_limited, limit_status, degrees, output ready);
endinterface

[rtl/tdl_cfg.sv]
// Configuration register file of the thermal derating limiter.
// Depends on tdl_pkg for cfg_t and register indexes.
module tdl_cfg import tdl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.avg_shift      <= 4'd6;
			cfg_q.limit_level    <= 8'd200;
			cfg_q.max_level      <= 8'd230;
			cfg_q.derating_slope <= 8'd8;
			cfg_q.degree_scale   <= 8'd128;
			cfg_q.degree_offset  <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AVG_SHIFT:      cfg_q.avg_shift      <= cfg_data[SHIFT_W-1:0];
				CFG_LIMIT_LEVEL:    cfg_q.limit_level    <= cfg_data;
				CFG_MAX_LEVEL:      cfg_q.max_level      <= cfg_data;
				CFG_DERATING_SLOPE: cfg_q.derating_slope <= cfg_data;
				CFG_DEGREE_SCALE:   cfg_q.degree_scale   <= cfg_data;
				CFG_DEGREE_OFFSET:  cfg_q.degree_offset  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/tdl_alu.sv]
// Shared arithmetic unit: accumulator update or one 14x8 multiply.
// Depends on tdl_pkg for alu_req_t and operation codes.
module tdl_alu import tdl_pkg::*; #(
	parameter int ACC_WIDTH = ACC_WIDTH_DEF,
	localparam int RES_W = (ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W
) (
	input  logic [ACC_WIDTH-1:0] acc_a,
	input  alu_req_t             req,
	output logic [RES_W-1:0]     res
);

	logic [ACC_WIDTH-1:0] acc_res;
	logic [PROD_W-1:0]    prod;

	// acc - byte + sample, wrapping at the accumulator width
	assign acc_res = acc_a - {{(ACC_WIDTH-SAMPLE_W){1'b0}}, req.sub_b}
	                 + {{(ACC_WIDTH-SAMPLE_W){1'b0}}, req.add_c};
	assign prod    = req.mul_a * req.mul_b;

	always_comb begin
		res = '0;
		unique case (req.op)
			ALU_OP_ACC: res[ACC_WIDTH-1:0] = acc_res;
			ALU_OP_MUL: res[PROD_W-1:0]    = prod;
			default:    res = '0;
		endcase
	end

endmodule

[rtl/thermal_derating_limiter_core.sv]
// Thermal derating limiter: moving-average temperature, PWM derating and cut-off.
// Each item passes through the single shared adder/multiplier in 4 sequencer steps;
//   the next item may be accepted in the last step while the result is handed off.
// A pending result waits in the output register; only the last step stalls on it.
// Reset (arst_n low, async) clears accumulator, latch, sequencer and output valid;
//   configuration registers return to their reset defaults; datapath registers are not reset.
module thermal_derating_limiter_core import tdl_pkg::*; #(
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tdl_in_if.sink                in_ch,
	tdl_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int RES_W = (ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W;

	// sequencer steps
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ACC  = 3'd1; // acc update
	localparam logic [2:0] ST_DEG  = 3'd2; // degrees multiply, classify
	localparam logic [2:0] ST_FAC  = 3'd3; // derating factor multiply
	localparam logic [2:0] ST_PWM  = 3'd4; // PWM multiply, load result

	cfg_t                 cfg;
	alu_req_t             req;
	logic [RES_W-1:0]     alu_res;
	logic [PROD_W-1:0]    prod;

	logic [2:0]           state_q;
	logic [ACC_WIDTH-1:0] acc_q;
	logic                 latch_q;
	logic [SAMPLE_W-1:0]  sample_q;
	logic [PWM_W-1:0]     pwm_q;
	logic [7:0]           avg_q;
	logic [7:0]           factor_q;
	logic [DEG_W-1:0]     deg_q;
	logic [STATUS_W-1:0]  stat_q;

	logic                 out_valid_q;
	logic [PWM_W-1:0]     out_pwm_q;
	logic [STATUS_W-1:0]  out_stat_q;
	logic [DEG_W-1:0]     out_deg_q;

	logic [ACC_WIDTH-1:0] acc_shifted;
	logic [7:0]           avg;
	logic [7:0]           diff;
	logic                 out_free;
	logic                 in_acc;
	logic [PWM_W-1:0]     pwm_sel;

	tdl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tdl_alu #(.ACC_WIDTH(ACC_WIDTH)) u_alu (
		.acc_a (acc_q),
		.req   (req),
		.res   (alu_res)
	);

	assign prod = alu_res[PROD_W-1:0];

	// average byte of the current accumulator
	assign acc_shifted = acc_q >> cfg.avg_shift;
	assign avg         = acc_shifted[7:0];
	assign diff        = avg_q - cfg.limit_level;

	// output register free this cycle
	assign out_free = !out_valid_q || out_ch.ready;

	// the next item may enter while the last step hands off its result
	assign in_ch.ready = (state_q == ST_IDLE) || (state_q == ST_PWM && out_free);
	assign in_acc      = in_ch.valid && in_ch.ready;

	// operand selection for the shared unit
	always_comb begin
		req.op    = ALU_OP_MUL;
		req.sub_b = avg;
		req.add_c = sample_q;
		req.mul_a = '0;
		req.mul_b = '0;
		unique case (state_q)
			ST_ACC: req.op = ALU_OP_ACC;
			ST_DEG: begin
				req.mul_a = {{(MUL_A_W-8){1'b0}}, avg};
				req.mul_b = cfg.degree_scale;
			end
			ST_FAC: begin
				req.mul_a = {{(MUL_A_W-8){1'b0}}, diff};
				req.mul_b = cfg.derating_slope;
			end
			ST_PWM: begin
				req.mul_a = pwm_q;
				req.mul_b = factor_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		unique case (stat_q)
			STAT_NORMAL:  pwm_sel = pwm_q;
			STAT_DERATED: pwm_sel = prod[PROD_W-1:8];
			default:      pwm_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
			latch_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_ACC;
				ST_ACC: begin
					acc_q   <= alu_res[ACC_WIDTH-1:0];
					state_q <= ST_DEG;
				end
				ST_DEG: begin
					if (avg < cfg.limit_level) latch_q <= 1'b0;
					else if (avg >= cfg.max_level) latch_q <= 1'b1;
					state_q <= ST_FAC;
				end
				ST_FAC: state_q <= ST_PWM;
				ST_PWM: begin
					if (in_acc) state_q <= ST_ACC;
					else if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= in_ch.adc_sample;
			pwm_q    <= in_ch.pwm_request;
		end
		if (state_q == ST_DEG) begin
			avg_q <= avg;
			deg_q <= {1'b0, prod[15:9]} + cfg.degree_offset;
			if (avg < cfg.limit_level) stat_q <= STAT_NORMAL;
			else if (avg < cfg.max_level) stat_q <= latch_q ? STAT_CUT : STAT_DERATED;
			else stat_q <= STAT_CUT;
		end
		if (state_q == ST_FAC) factor_q <= 8'hFF - prod[7:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PWM && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PWM && out_free) begin
			out_pwm_q  <= pwm_sel;
			out_stat_q <= stat_q;
			out_deg_q  <= deg_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.pwm_limited  = out_pwm_q;
	assign out_ch.limit_status = out_stat_q;
	assign out_ch.degrees      = out_deg_q;

endmodule

[rtl/tdl_checker.sv]
// Port-level checker for the thermal derating limiter core, with its bind.
// Depends on tdl_pkg and thermal_derating_limiter_core_macros.svh.
`include "thermal_derating_limiter_core_macros.svh"

module tdl_checker import tdl_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [PWM_W-1:0]    pwm_limited,
	input logic [STATUS_W-1:0] limit_status,
	input logic [DEG_W-1:0]    degrees
);

	// cut-off results carry no drive
	`TDL_ASSERT_NOW(a_cut_zero, out_valid && limit_status == STAT_CUT, pwm_limited == '0, "cut-off item with nonzero pwm")
	// busy right after an accept
	`TDL_ASSERT_NEXT(a_busy_1, in_valid && in_ready, !in_ready, "ready one cycle after accept")
	// still busy when the accepted item reaches the derating factor step
	`TDL_ASSERT_NOW(a_busy_3, in_valid && in_ready, ##3 !in_ready, "ready three cycles after accept")
	// stalled result holds
	`TDL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pwm_limited) && $stable(limit_status) && $stable(degrees), "stalled result changed")

endmodule

bind thermal_derating_limiter_core tdl_checker u_tdl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.pwm_limited  (out_ch.pwm_limited),
	.limit_status (out_ch.limit_status),
	.degrees      (out_ch.degrees)
);
